// ----- rtl/fjss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjss_pkg
// Shared types, constants and the CRC-32 update for the journal slot scanner.
// ----------------------------------------------------------------------------
package fjss_pkg;

    localparam int SLOT_WORDS_DEF = 48;
    localparam int CRC_WORDS_DEF  = 46;
    localparam int MAX_SLOTS_DEF  = 1023;

    localparam int SLOT_W   = 10;
    localparam int OUT_DW   = 120;
    localparam int CFG_IW   = 3;
    localparam int Q_DEPTH  = 4;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [31:0] MAGIC_RST   = 32'h4B44_5443;
    localparam logic [15:0] VERSION_RST = 16'd2;
    localparam logic [15:0] PAYLOAD_RST = 16'd171;
    localparam logic [31:0] COMMIT_RST  = 32'hA55A_A55A;
    localparam logic [9:0]  SLOTCNT_RST = 10'd682;

    localparam logic [CFG_IW-1:0] REG_MAGIC   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_VERSION = 3'd1;
    localparam logic [CFG_IW-1:0] REG_PAYLOAD = 3'd2;
    localparam logic [CFG_IW-1:0] REG_COMMIT  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_SLOTCNT = 3'd4;

    localparam logic [1:0] VERDICT_VALID   = 2'd0;
    localparam logic [1:0] VERDICT_INVALID = 2'd1;
    localparam logic [1:0] VERDICT_ERASED  = 2'd2;

    localparam logic [SLOT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] payload;
        logic [31:0] commit;
        logic [9:0]  slot_count;
    } cfg_t;

    // clear: start of a new scan, no result; otherwise one slot verdict
    typedef struct packed {
        logic              clear;
        logic [1:0]        verdict;
        logic [31:0]       seq;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] next_free;
        logic              full;
        logic              done;
    } entry_t;

    typedef logic [31:0][31:0] crc_cols_t;

    function automatic crc_cols_t build_cols();
        crc_cols_t cols;
        logic [31:0] c;
        for (int i = 0; i < 32; i++)
        begin
            c = 32'h1 << i;
            for (int k = 0; k < 32; k++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            cols[i] = c;
        end
        return cols;
    endfunction

    localparam crc_cols_t CRC_COLS = build_cols();

    // four reflected byte steps, low byte first, as one linear map
    function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [31:0] w);
        logic [31:0] v;
        logic [31:0] acc;
        v   = crc ^ w;
        acc = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                acc = acc ^ CRC_COLS[i];
            end
        end
        return acc;
    endfunction

endpackage

// ----- rtl/flash_journal_slot_scanner_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_journal_slot_scanner_unit
// Validates fixed-size flash journal slots from a word stream and reports a
// verdict with running scan status after each judged slot.
//
//  channel  | direction | contents
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | one journal word or a scan restart per transfer
//  m_axis   | out       | one result per judged slot, tlast on last of scan
//  cfg      | in        | register write, index and data, no read-back
//
//  One word per cycle is taken while the verdict queue is not full; the CRC-32
//  of a word is one XOR network. The result of the word that closes a slot is
//  held first in the verdict queue, then in the output register.
//  The 4-entry queue lets words keep flowing while a result is held by
//  m_axis_tready; s_axis_tready drops only when the queue is full.
//  Reset clears scan state and loads the register defaults.
// ----------------------------------------------------------------------------
module flash_journal_slot_scanner_unit #(
    parameter int SLOT_WORDS = fjss_pkg::SLOT_WORDS_DEF,
    parameter int CRC_WORDS  = fjss_pkg::CRC_WORDS_DEF,
    parameter int MAX_SLOTS  = fjss_pkg::MAX_SLOTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,   // flash_word
    input  logic [0:0]                    s_axis_tuser,   // mode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // slot_index, slot_sequence, valid_total, error_total, newest_seq,
    // latest_slot, found_valid, next_free_slot, region_full, zero pad
    output logic [fjss_pkg::OUT_DW-1:0]   m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,   // verdict
    output logic                          m_axis_tlast,   // scan_done
    input  logic                          cfg_wr_en,
    input  logic [fjss_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [31:0]                   cfg_wdata
);

    fjss_pkg::cfg_t   cfg_reg;
    fjss_pkg::entry_t push_data;
    fjss_pkg::entry_t pop_data;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic      <= fjss_pkg::MAGIC_RST;
            cfg_reg.version    <= fjss_pkg::VERSION_RST;
            cfg_reg.payload    <= fjss_pkg::PAYLOAD_RST;
            cfg_reg.commit     <= fjss_pkg::COMMIT_RST;
            cfg_reg.slot_count <= fjss_pkg::SLOTCNT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                fjss_pkg::REG_MAGIC:   cfg_reg.magic      <= cfg_wdata;
                fjss_pkg::REG_VERSION: cfg_reg.version    <= cfg_wdata[15:0];
                fjss_pkg::REG_PAYLOAD: cfg_reg.payload    <= cfg_wdata[15:0];
                fjss_pkg::REG_COMMIT:  cfg_reg.commit     <= cfg_wdata;
                fjss_pkg::REG_SLOTCNT: cfg_reg.slot_count <= cfg_wdata[9:0];
                default:
                begin
                end
            endcase
        end
    end

    fjss_front #(
        .SLOT_WORDS (SLOT_WORDS),
        .CRC_WORDS  (CRC_WORDS),
        .MAX_SLOTS  (MAX_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser[0]),
        .in_word   (s_axis_tdata),
        .cfg       (cfg_reg),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    fjss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (q_valid)
    );

    fjss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    // erased slot closes the scan and is itself the next free slot
    a_erased_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == fjss_pkg::VERDICT_ERASED) |->
        (m_axis_tlast && m_axis_tdata[114:105] == m_axis_tdata[9:0]))
        else $error("erased result without scan end or with wrong free slot");

    // a valid slot becomes the latest valid slot
    a_valid_latest: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == fjss_pkg::VERDICT_VALID) |->
        (m_axis_tdata[104] && m_axis_tdata[103:94] == m_axis_tdata[9:0] &&
         m_axis_tdata[93:62] == m_axis_tdata[41:10]))
        else $error("valid result not reflected in latest slot");

    // a judged slot advances the free slot by one
    a_next_free: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != fjss_pkg::VERDICT_ERASED) |->
        (m_axis_tdata[114:105] == m_axis_tdata[9:0] + 10'd1))
        else $error("free slot not one past judged slot");

endmodule

// ----- rtl/fjss_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjss_queue
// Short FIFO of slot verdicts between the word front end and the tally stage.
// ----------------------------------------------------------------------------
module fjss_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fjss_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output fjss_pkg::entry_t pop_data,
    output logic             not_empty
);

    localparam int PW = $clog2(fjss_pkg::Q_DEPTH);
    localparam int CW = $clog2(fjss_pkg::Q_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(fjss_pkg::Q_DEPTH);

    fjss_pkg::entry_t mem [fjss_pkg::Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full      = (count_reg == DEPTH_C);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(fjss_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(fjss_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/fjss_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjss_front
// Word front end: tracks slot position, runs the CRC and header checks and
// queues one verdict per judged slot plus a marker for each scan restart.
// ----------------------------------------------------------------------------
module fjss_front #(
    parameter int SLOT_WORDS = fjss_pkg::SLOT_WORDS_DEF,
    parameter int CRC_WORDS  = fjss_pkg::CRC_WORDS_DEF,
    parameter int MAX_SLOTS  = fjss_pkg::MAX_SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_mode,
    input  logic [31:0]      in_word,
    input  fjss_pkg::cfg_t   cfg,
    output logic             push,
    output fjss_pkg::entry_t push_data,
    input  logic             q_full
);

    localparam int POS_W = $clog2(SLOT_WORDS);
    localparam int SW    = fjss_pkg::SLOT_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(SLOT_WORDS - 1);
    localparam logic [POS_W-1:0] CRC_POS  = POS_W'(CRC_WORDS);
    localparam logic [POS_W-1:0] VER_POS  = POS_W'(1);
    localparam logic [POS_W-1:0] SEQ_POS  = POS_W'(2);
    localparam logic [SW:0]      MAX_LIM  = (SW+1)'(MAX_SLOTS);

    logic [POS_W-1:0] pos_reg;
    logic [31:0]      crc_reg;
    logic             hok_reg;
    logic [31:0]      held_reg;
    logic [SW-1:0]    cur_reg;
    logic             finished_reg;

    logic             accept;
    logic [SW:0]      limit;
    logic [31:0]      crc_in;
    logic [31:0]      crc_upd;
    logic             hok;
    logic [31:0]      seq;
    logic             is_erased;
    logic             is_last;
    logic [SW:0]      slot1;
    logic             done;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        limit = {1'b0, cfg.slot_count};
        if (limit > MAX_LIM)
        begin
            limit = MAX_LIM;
        end
        if (limit == '0)
        begin
            limit = (SW+1)'(1);
        end

        crc_in  = (pos_reg == '0) ? fjss_pkg::ALL_ONES : crc_reg;
        crc_upd = fjss_pkg::crc_next(crc_in, in_word);

        hok = (pos_reg == '0) ? (in_word == cfg.magic) : hok_reg;
        if (pos_reg == VER_POS &&
            (in_word[15:0] != cfg.version || in_word[31:16] != cfg.payload))
        begin
            hok = 1'b0;
        end
        if (pos_reg == CRC_POS && (crc_in ^ fjss_pkg::ALL_ONES) != in_word)
        begin
            hok = 1'b0;
        end

        seq       = (pos_reg == SEQ_POS) ? in_word : held_reg;
        is_erased = (pos_reg == '0) && (in_word == fjss_pkg::ALL_ONES);
        is_last   = (pos_reg == LAST_POS);
        slot1     = {1'b0, cur_reg} + 1'b1;
        done      = (slot1 >= limit);

        push_data.clear = in_mode;
        push_data.slot  = cur_reg;
        if (is_erased)
        begin
            push_data.verdict   = fjss_pkg::VERDICT_ERASED;
            push_data.seq       = '0;
            push_data.next_free = cur_reg;
            push_data.full      = (slot1 > limit);
            push_data.done      = 1'b1;
        end
        else
        begin
            push_data.verdict   = (hok && in_word == cfg.commit) ? fjss_pkg::VERDICT_VALID
                                                                 : fjss_pkg::VERDICT_INVALID;
            push_data.seq       = seq;
            push_data.next_free = slot1[SW-1:0];
            push_data.full      = ((slot1 + 1'b1) > limit);
            push_data.done      = done;
        end

        push = accept && (in_mode || (!finished_reg && (is_erased || is_last)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            crc_reg      <= fjss_pkg::ALL_ONES;
            hok_reg      <= 1'b1;
            held_reg     <= '0;
            cur_reg      <= '0;
            finished_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (in_mode)
            begin
                pos_reg      <= '0;
                crc_reg      <= fjss_pkg::ALL_ONES;
                hok_reg      <= 1'b1;
                held_reg     <= '0;
                cur_reg      <= '0;
                finished_reg <= 1'b0;
            end
            else if (!finished_reg)
            begin
                if (is_erased)
                begin
                    finished_reg <= 1'b1;
                end
                else if (is_last)
                begin
                    pos_reg  <= '0;
                    crc_reg  <= fjss_pkg::ALL_ONES;
                    hok_reg  <= 1'b1;
                    held_reg <= seq;
                    if (done)
                    begin
                        finished_reg <= 1'b1;
                    end
                    else
                    begin
                        cur_reg <= slot1[SW-1:0];
                    end
                end
                else
                begin
                    pos_reg  <= pos_reg + 1'b1;
                    hok_reg  <= hok;
                    held_reg <= seq;
                    crc_reg  <= (pos_reg < CRC_POS) ? crc_upd : crc_in;
                end
            end
        end
    end

endmodule

// ----- rtl/fjss_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjss_back
// Tally stage: keeps scan counters and the last valid slot, forms the result
// and holds it in the output register.
// ----------------------------------------------------------------------------
module fjss_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  fjss_pkg::entry_t             q_data,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fjss_pkg::OUT_DW-1:0]  out_data,
    output logic [1:0]                   out_user,
    output logic                         out_last
);

    localparam int SW = fjss_pkg::SLOT_W;

    logic [SW-1:0] valid_cnt_reg;
    logic [SW-1:0] error_cnt_reg;
    logic [31:0]   last_seq_reg;
    logic [SW-1:0] last_slot_reg;
    logic          any_reg;
    logic          out_valid_reg;
    logic [fjss_pkg::OUT_DW-1:0] out_data_reg;
    logic [1:0]    out_user_reg;
    logic          out_last_reg;

    logic [SW-1:0] valid_cnt_next;
    logic [SW-1:0] error_cnt_next;
    logic [31:0]   last_seq_next;
    logic [SW-1:0] last_slot_next;
    logic          any_next;
    logic          out_free;
    logic          emit;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = q_valid && (q_data.clear || out_free);
    assign emit      = pop && !q_data.clear;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        valid_cnt_next = valid_cnt_reg;
        error_cnt_next = error_cnt_reg;
        last_seq_next  = last_seq_reg;
        last_slot_next = last_slot_reg;
        any_next       = any_reg;
        case (q_data.verdict)
            fjss_pkg::VERDICT_VALID:
            begin
                if (valid_cnt_reg != fjss_pkg::CNT_MAX)
                begin
                    valid_cnt_next = valid_cnt_reg + 1'b1;
                end
                last_seq_next  = q_data.seq;
                last_slot_next = q_data.slot;
                any_next       = 1'b1;
            end
            fjss_pkg::VERDICT_INVALID:
            begin
                if (error_cnt_reg != fjss_pkg::CNT_MAX)
                begin
                    error_cnt_next = error_cnt_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= {4'b0, q_data.full, q_data.next_free, any_next, last_slot_next,
                             last_seq_next, error_cnt_next, valid_cnt_next, q_data.seq,
                             q_data.slot};
            out_user_reg <= q_data.verdict;
            out_last_reg <= q_data.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_cnt_reg <= '0;
            error_cnt_reg <= '0;
            last_seq_reg  <= '0;
            last_slot_reg <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && q_data.clear)
            begin
                valid_cnt_reg <= '0;
                error_cnt_reg <= '0;
                last_seq_reg  <= '0;
                last_slot_reg <= '0;
                any_reg       <= 1'b0;
            end
            else if (emit)
            begin
                valid_cnt_reg <= valid_cnt_next;
                error_cnt_reg <= error_cnt_next;
                last_seq_reg  <= last_seq_next;
                last_slot_reg <= last_slot_next;
                any_reg       <= any_next;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
